>>> rtl/core/bfm_pkg.sv
// Package for the 7x7 box mean filter: shared widths, constants, the
// register index codes, the line store word type, the stage-one item and the slot step.
// No dependencies.
package bfm_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_MAX_COLS   = 512;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_IMAGE_DIM  = 512;

    // Window geometry
    localparam int MIN_DIM        = 7;
    localparam int WIN_LEAD       = 6;   // pixels before the right/lower edge
    localparam int CENTRE_OFFSET  = 3;
    localparam int NUM_LINES      = 6;
    localparam int SLOT_W         = 3;
    localparam int LAST_SLOT      = NUM_LINES - 1;

    // Field widths
    localparam int PIX_W          = 8;
    localparam int HSUM_W         = 11;
    localparam int TOTAL_W        = 14;
    localparam int MEAN_W         = 8;
    localparam int OUT_ROW_W      = 10;
    localparam int OUT_COL_W      = 9;
    localparam int COLS_REG_W     = 10;
    localparam int ROWS_REG_W     = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_FIELDS_W   = OUT_ROW_W + OUT_COL_W + MEAN_W;
    localparam int OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Divide by 49 as multiply by ceil(2^20 / 49), exact below 43690
    localparam int RECIP_49       = 21400;
    localparam int RECIP_W        = 15;
    localparam int RECIP_SHIFT    = 20;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_COLS = 1'b0,
        CFG_IMAGE_ROWS = 1'b1
    } cfg_index_t;

    typedef logic [SLOT_W-1:0]                   slot_t;
    typedef logic [HSUM_W-1:0]                   hsum_t;
    typedef logic [NUM_LINES-1:0][HSUM_W-1:0]    line_word_t;

    // One pixel after the position stage
    typedef struct packed {
        logic                 emit;     // full window present
        logic                 wr;       // horizontal sum goes to the store
        slot_t                slot;     // row modulo six
        hsum_t                hsum;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
    } s1_item_t;

    // Row modulo six, advanced by one row
    function automatic slot_t next_slot(input slot_t slot);
        slot_t res;
        if (slot == slot_t'(LAST_SLOT)) begin
            res = '0;
        end else begin
            res = slot + slot_t'(1);
        end
        return res;
    endfunction

endpackage

>>> rtl/core/box_filter_7x7_mean_top.sv
// Top level of the 7x7 box mean filter: stream ports, configuration
// registers, pipeline advance. Uses bfm_pkg, bfm_pos_ctrl, bfm_line_mem, bfm_mean_out.
//
//  channel   direction  payload                                   handshake
//  s_axis    in         tdata: pixel; tuser: frame_start          tvalid/tready
//  m_axis    out        tdata: out_row, out_col, mean_value       tvalid/tready
//  cfg       in         cfg_index, cfg_data                       cfg_valid/cfg_ready
//
// One pixel a clock unless the output stalls; results pass s1, s2 and output regs.
// The line store has one read port and one lane-write port; a column is read
// and rewritten at least seven pixels apart, so no forwarding is needed.
// Reset clears counters, recent pixels and valid flags; the line store is
// not cleared and holds nothing meaningful until written.
// A full output register that is not taken holds the whole pipeline and
// drops s_axis_tready.
module box_filter_7x7_mean_top
    import bfm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel
    input  logic                   s_axis_tuser,   // [0] frame_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [9:0] out_row, [18:10] out_col,
                                                   // [26:19] mean_value, rest zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_AW = $clog2(MAX_COLS);
    localparam int COL_CW = $clog2(MAX_COLS + 1);
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);

    logic [COLS_REG_W-1:0] image_cols_reg;
    logic [ROWS_REG_W-1:0] image_rows_reg;
    logic [COL_CW-1:0]     cols_used;
    logic [ROW_CW-1:0]     rows_used;

    logic                  adv;
    logic                  accept;
    logic [COL_AW-1:0]     rd_addr;
    logic                  s1_valid;
    s1_item_t              s1_item;
    logic [COL_AW-1:0]     s1_col;
    line_word_t            lines;
    logic                  wr_en;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_cols_reg <= COLS_REG_W'(DEF_IMAGE_DIM);
            image_rows_reg <= ROWS_REG_W'(DEF_IMAGE_DIM);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_COLS: image_cols_reg <= cfg_data[COLS_REG_W-1:0];
                CFG_IMAGE_ROWS: image_rows_reg <= cfg_data[ROWS_REG_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Clamp the frame size to the supported range
    always_comb begin
        if (32'(image_cols_reg) < 32'(MIN_DIM)) begin
            cols_used = COL_CW'(MIN_DIM);
        end else if (32'(image_cols_reg) > 32'(MAX_COLS)) begin
            cols_used = COL_CW'(MAX_COLS);
        end else begin
            cols_used = COL_CW'(image_cols_reg);
        end

        if (32'(image_rows_reg) < 32'(MIN_DIM)) begin
            rows_used = ROW_CW'(MIN_DIM);
        end else if (32'(image_rows_reg) > 32'(MAX_ROWS)) begin
            rows_used = ROW_CW'(MAX_ROWS);
        end else begin
            rows_used = ROW_CW'(image_rows_reg);
        end
    end

    // Advance the pipeline unless a result waits untaken
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign wr_en         = adv && s1_valid && s1_item.wr;

    bfm_pos_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .adv         (adv),
        .pixel       (s_axis_tdata[PIX_W-1:0]),
        .frame_start (s_axis_tuser),
        .cols_used   (cols_used),
        .rows_used   (rows_used),
        .rd_addr     (rd_addr),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .s1_col      (s1_col)
    );

    bfm_line_mem #(
        .MAX_COLS (MAX_COLS)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (lines),
        .wr_en   (wr_en),
        .wr_addr (s1_col),
        .wr_lane (s1_item.slot),
        .wr_data (s1_item.hsum)
    );

    bfm_mean_out u_mean_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .lines    (lines),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_axis_tdata)
    );

    // A column is never read and written in the same cycle
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && accept) |-> (s1_col != rd_addr))
        else $error("line store read and write hit the same column");

    // Row slot stays within the six lines
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid |-> (s1_item.slot <= slot_t'(LAST_SLOT)))
        else $error("row slot out of range");

    // A pixel that completes a window also refreshes its line
    a_emit_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid && s1_item.emit && adv) |-> wr_en)
        else $error("window result without line store update");

endmodule

>>> rtl/core/bfm_pos_ctrl.sv
// Position stage of the box mean filter: row/column counters, the six
// most recent pixels and the 7-pixel horizontal sum. Depends on bfm_pkg.
module bfm_pos_ctrl
    import bfm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    localparam int COL_AW  = $clog2(MAX_COLS),
    localparam int COL_CW  = $clog2(MAX_COLS + 1),
    localparam int ROW_AW  = $clog2(MAX_ROWS),
    localparam int ROW_CW  = $clog2(MAX_ROWS + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              adv,
    input  logic [PIX_W-1:0]  pixel,
    input  logic              frame_start,
    input  logic [COL_CW-1:0] cols_used,
    input  logic [ROW_CW-1:0] rows_used,
    output logic [COL_AW-1:0] rd_addr,
    output logic              s1_valid,
    output s1_item_t          s1_item,
    output logic [COL_AW-1:0] s1_col
);

    logic [COL_AW-1:0]  col_reg, col_next;
    logic [ROW_AW-1:0]  row_reg, row_next;
    slot_t              slot_reg, slot_next;
    logic [PIX_W-1:0]   recent_reg [NUM_LINES];
    logic               s1_valid_reg;
    s1_item_t           s1_item_reg, s1_item_next;
    logic [COL_AW-1:0]  s1_col_reg;

    logic [COL_CW-1:0]  col_a, col_c, col_inc;
    logic [ROW_CW-1:0]  row_a, row_b, row_c, row_inc;
    slot_t              slot_a, slot_b, slot_c;
    hsum_t              hsum;

    // Settle the position of this pixel, then the position of the next one
    always_comb begin
        col_a  = frame_start ? '0 : COL_CW'(col_reg);
        row_a  = frame_start ? '0 : ROW_CW'(row_reg);
        slot_a = frame_start ? '0 : slot_reg;

        if (col_a >= cols_used) begin
            col_c  = '0;
            row_b  = row_a + ROW_CW'(1);
            slot_b = next_slot(slot_a);
        end else begin
            col_c  = col_a;
            row_b  = row_a;
            slot_b = slot_a;
        end

        if (row_b >= rows_used) begin
            row_c  = '0;
            slot_c = '0;
        end else begin
            row_c  = row_b;
            slot_c = slot_b;
        end

        col_inc = col_c + COL_CW'(1);
        row_inc = row_c + ROW_CW'(1);
        if (col_inc >= cols_used) begin
            col_next = '0;
            if (row_inc >= rows_used) begin
                row_next  = '0;
                slot_next = '0;
            end else begin
                row_next  = ROW_AW'(row_inc);
                slot_next = next_slot(slot_c);
            end
        end else begin
            col_next  = COL_AW'(col_inc);
            row_next  = ROW_AW'(row_c);
            slot_next = slot_c;
        end
    end

    // Horizontal sum of this pixel and the six before it
    always_comb begin
        hsum = HSUM_W'(pixel);
        for (int i = 0; i < NUM_LINES; i++) begin
            hsum = hsum + HSUM_W'(recent_reg[i]);
        end
    end

    always_comb begin
        s1_item_next.wr      = (col_c >= COL_CW'(WIN_LEAD));
        s1_item_next.emit    = (col_c >= COL_CW'(WIN_LEAD)) && (row_c >= ROW_CW'(WIN_LEAD));
        s1_item_next.slot    = slot_c;
        s1_item_next.hsum    = hsum;
        s1_item_next.out_row = OUT_ROW_W'(row_c - ROW_CW'(CENTRE_OFFSET));
        s1_item_next.out_col = OUT_COL_W'(col_c - COL_CW'(CENTRE_OFFSET));
    end

    // Advance counters and the recent-pixel line on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
            for (int i = 0; i < NUM_LINES; i++) begin
                recent_reg[i] <= '0;
            end
        end else if (accept) begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            slot_reg      <= slot_next;
            recent_reg[0] <= pixel;
            for (int i = 1; i < NUM_LINES; i++) begin
                recent_reg[i] <= recent_reg[i-1];
            end
        end
    end

    // Stage-one valid follows the pipeline advance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= accept;
        end
    end

    // Hold the stage-one payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s1_item_next;
            s1_col_reg  <= COL_AW'(col_c);
        end
    end

    assign rd_addr  = COL_AW'(col_c);
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
    assign s1_col   = s1_col_reg;

endmodule

>>> rtl/core/bfm_line_mem.sv
// Line store of the box mean filter: one word per column holding the
// horizontal sums of six rows, lane-written, registered read. Uses bfm_pkg.
module bfm_line_mem
    import bfm_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    localparam int COL_AW  = $clog2(MAX_COLS)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [COL_AW-1:0] rd_addr,
    output line_word_t        rd_data,
    input  logic              wr_en,
    input  logic [COL_AW-1:0] wr_addr,
    input  slot_t             wr_lane,
    input  hsum_t             wr_data
);

    line_word_t line_array [MAX_COLS];
    line_word_t rd_data_reg;

    // Write one lane of a column word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_array[wr_addr][wr_lane] <= wr_data;
        end
    end

    // Read the whole column word; hold it while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/bfm_mean_out.sv
// Window sum, divide-by-49 and output register of the box mean filter.
// Depends on bfm_pkg.
module bfm_mean_out
    import bfm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   s1_valid,
    input  s1_item_t               s1_item,
    input  line_word_t             lines,
    output logic                   m_valid,
    output logic [OUT_TDATA_W-1:0] m_data
);

    localparam int PROD_W = TOTAL_W + RECIP_W;
    localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;

    logic                   s2_valid_reg;
    logic [TOTAL_W-1:0]     s2_total_reg, s2_total_next;
    logic [OUT_ROW_W-1:0]   s2_row_reg;
    logic [OUT_COL_W-1:0]   s2_col_reg;
    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [PROD_W-1:0]      prod;

    // Add the six stored row sums to the current one
    always_comb begin
        s2_total_next = TOTAL_W'(s1_item.hsum);
        for (int i = 0; i < NUM_LINES; i++) begin
            s2_total_next = s2_total_next + TOTAL_W'(lines[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid && s1_item.emit;
            m_valid_reg  <= s2_valid_reg;
        end
    end

    // Stage-two payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_total_reg <= s2_total_next;
            s2_row_reg   <= s1_item.out_row;
            s2_col_reg   <= s1_item.out_col;
        end
    end

    // Multiply by the reciprocal and pack row, column, mean
    always_comb begin
        prod        = PROD_W'(s2_total_reg) * PROD_W'(RECIP_49);
        m_data_next = {{PAD_W{1'b0}}, prod[RECIP_SHIFT +: MEAN_W], s2_col_reg, s2_row_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for box_filter_7x7_mean_top: predicts the 7x7 window
// means from the accepted pixel beats and compares every result beat in order.
// Depends on bfm_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;
    import bfm_pkg::*;

    localparam int MAX_COLS      = DEF_MAX_COLS;
    localparam int MAX_ROWS      = DEF_MAX_ROWS;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int WINDOW_AREA   = 49;
    localparam int SETTLE_CYCLES = 8;     // covers the three-stage pipeline
    localparam int DRAIN_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 50;
    localparam int RANDOM_ITEMS  = 1100;
    localparam longint TIMEOUT_NS = 10_000_000;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic [MEAN_W-1:0]    mean;
    } window_mean_t;

    typedef enum int {
        PIX_UNIFORM,
        PIX_WHITE,
        PIX_BLACK,
        PIX_MOSTLY_WHITE,
        PIX_TWO_LEVEL
    } pixel_style_t;

    // Window mean predictor with its queue of means still owed by the block
    class box_mean_scoreboard;
        logic [PIX_W-1:0]  last_six [NUM_LINES];
        logic [HSUM_W-1:0] hsum_lines [NUM_LINES * MAX_COLS];
        int unsigned       row_pos;
        int unsigned       col_pos;
        logic [COLS_REG_W-1:0] cols_reg;
        logic [ROWS_REG_W-1:0] rows_reg;
        window_mean_t      means_due [$];

        function new();
            foreach (last_six[k]) last_six[k] = '0;
            foreach (hsum_lines[k]) hsum_lines[k] = '0;
            row_pos  = 0;
            col_pos  = 0;
            cols_reg = COLS_REG_W'(DEF_IMAGE_DIM);
            rows_reg = ROWS_REG_W'(DEF_IMAGE_DIM);
        endfunction

        function int unsigned used_cols();
            int unsigned v;
            v = cols_reg;
            if (v < MIN_DIM) v = MIN_DIM;
            if (v > MAX_COLS) v = MAX_COLS;
            return v;
        endfunction

        function int unsigned used_rows();
            int unsigned v;
            v = rows_reg;
            if (v < MIN_DIM) v = MIN_DIM;
            if (v > MAX_ROWS) v = MAX_ROWS;
            return v;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_IMAGE_COLS) begin
                cols_reg = value[COLS_REG_W-1:0];
            end else begin
                rows_reg = value[ROWS_REG_W-1:0];
            end
        endfunction

        function bit at_frame_origin();
            return (row_pos == 0) && (col_pos == 0);
        endfunction

        function int pending();
            return means_due.size();
        endfunction

        // Take one accepted pixel: advance position, update stores, owe a mean
        function void note_pixel(logic [PIX_W-1:0] px, logic start);
            int unsigned cols, rows, r, c, hsum, total;
            int k;
            window_mean_t due;
            cols = used_cols();
            rows = used_rows();
            if (start) begin
                row_pos = 0;
                col_pos = 0;
            end
            // wrap a position left past the size by a register change
            if (col_pos >= cols) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= rows) row_pos = 0;
            r = row_pos;
            c = col_pos;

            if (c >= WIN_LEAD) begin
                hsum = px;
                for (k = 0; k < NUM_LINES; k++) hsum += last_six[k];
                if (r >= WIN_LEAD) begin
                    total = hsum;
                    for (k = 0; k < NUM_LINES; k++) total += hsum_lines[k * MAX_COLS + c];
                    due.row  = OUT_ROW_W'(r - CENTRE_OFFSET);
                    due.col  = OUT_COL_W'(c - CENTRE_OFFSET);
                    due.mean = MEAN_W'(total / WINDOW_AREA);
                    means_due.push_back(due);
                end
                hsum_lines[(r % NUM_LINES) * MAX_COLS + c] = HSUM_W'(hsum);
            end

            for (k = NUM_LINES - 1; k > 0; k--) last_six[k] = last_six[k-1];
            last_six[0] = px;

            col_pos = c + 1;
            if (col_pos >= cols) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos >= rows) row_pos = 0;
            end
        endfunction

        // Compare one result beat with the oldest owed mean; empty string on match
        function string check_result(logic [OUT_TDATA_W-1:0] beat);
            window_mean_t want;
            logic [OUT_ROW_W-1:0] got_row;
            logic [OUT_COL_W-1:0] got_col;
            logic [MEAN_W-1:0]    got_mean;
            string msg;
            got_row  = beat[OUT_ROW_W-1:0];
            got_col  = beat[OUT_ROW_W +: OUT_COL_W];
            got_mean = beat[OUT_ROW_W + OUT_COL_W +: MEAN_W];
            if (means_due.size() == 0) begin
                return $sformatf("result row %0d col %0d mean %0d with none owed",
                                 got_row, got_col, got_mean);
            end
            want = means_due.pop_front();
            msg = "";
            if (got_row !== want.row)
                msg = {msg, $sformatf(" row got %0d", got_row)};
            if (got_col !== want.col)
                msg = {msg, $sformatf(" col got %0d", got_col)};
            if (got_mean !== want.mean)
                msg = {msg, $sformatf(" mean got %0d want %0d", got_mean, want.mean)};
            if (beat[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
                msg = {msg, " padding bits not zero"};
            if (msg != "")
                msg = $sformatf("at row %0d col %0d:%s", want.row, want.col, msg);
            return msg;
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // [7:0] pixel
    logic                   s_axis_tuser = 1'b0;  // [0] frame_start
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [9:0] out_row, [18:10] out_col,
                                                  // [26:19] mean_value
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_IMAGE_COLS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    box_mean_scoreboard sb;
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    phase_count = 0;
    int    narrowest_cols = DEF_IMAGE_DIM;   // fewest columns used since the last frame start
    string verdict;

    box_filter_7x7_mean_top #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic report_mismatch(input string what);
        if (errors < MAX_REPORTS) $display("tb: mismatch %s", what);
        errors++;
    endtask

    // Check each result beat and stall the result side at random
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            verdict = sb.check_result(m_axis_tdata);
            if (verdict != "") report_mismatch(verdict);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one pixel beat, after a random gap, and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic start);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tuser  <= start;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_pixel(px, start);
        if (start) narrowest_cols = sb.used_cols();
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Stop offering pixels and let every owed mean come out
    task automatic drain();
        int waited;
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input pixel_style_t style);
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom);
        case (style)
            PIX_WHITE:        px = {PIX_W{1'b1}};
            PIX_BLACK:        px = '0;
            PIX_MOSTLY_WHITE: if ($urandom_range(0, 15) != 0) px = {PIX_W{1'b1}};
            PIX_TWO_LEVEL:    px = $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
            default: ;
        endcase
        return px;
    endfunction

    // Rotate the idling pattern: none, sender gaps, result stalls, both
    task automatic set_idling();
        case (phase_count % 4)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 65;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 65;
            end
            default: begin
                send_idle_pct  = 23;
                recv_stall_pct = 23;
            end
        endcase
        phase_count++;
    endtask

    // Reconfigure while idle, then stream pixels; a frame start is forced when asked or
    // where the new width would reach line-store columns not written in this frame
    task automatic run_phase(input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [CFG_DATA_W-1:0] rows_val,
                             input int count, input pixel_style_t style,
                             input bit force_open, input bit noisy);
        bit   open_frame;
        logic start;
        int   n;
        drain();
        write_reg(CFG_IMAGE_COLS, cols_val);
        write_reg(CFG_IMAGE_ROWS, rows_val);
        open_frame = force_open || (sb.used_cols() > narrowest_cols);
        if (sb.used_cols() < narrowest_cols) narrowest_cols = sb.used_cols();
        set_idling();
        for (n = 0; n < count; n++) begin
            if (n == 0)
                start = open_frame || (sb.at_frame_origin() && $urandom_range(0, 1));
            else if (sb.at_frame_origin())
                start = $urandom_range(0, 1);
            else
                start = noisy && ($urandom_range(0, 49) == 0);
            send_pixel(pick_pixel(style), start);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] cols_val, rows_val;
        pixel_style_t style;
        int random_sent, count, k, pick;
        logic [PIX_W-1:0] px;

        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset sizes: extreme pixel values and a frame start in mid-row
        set_idling();
        for (k = 0; k < 16; k++) begin
            case (k % 3)
                0:       px = '0;
                1:       px = {PIX_W{1'b1}};
                default: px = PIX_W'(1 << (k % PIX_W));
            endcase
            send_pixel(px, (k == 0) || (k == 10));
        end

        // Sizes below the minimum: one all-white frame, then wrap into an all-black one
        run_phase('0, '0, MIN_DIM * MIN_DIM, PIX_WHITE, 1'b1, 1'b0);
        run_phase(CFG_DATA_W'(6), CFG_DATA_W'(6), MIN_DIM * MIN_DIM, PIX_BLACK, 1'b0, 1'b0);

        // Width above the maximum (masked, then clamped): one widest row and part of the next
        run_phase('1, CFG_DATA_W'(MIN_DIM), MAX_COLS + 4 * MIN_DIM, PIX_UNIFORM, 1'b1, 1'b0);

        // Height above the maximum: carry on from the wide rows without a frame start,
        // so the result rows show where the clamped width ended
        run_phase(CFG_DATA_W'(3), '1, 4 * MIN_DIM * MIN_DIM, PIX_UNIFORM,
                  1'b0, 1'b0);

        // Random sizes, mostly small, with random pixel styles
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                cols_val = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
            else if (pick == 1)
                cols_val = CFG_DATA_W'($urandom_range(MAX_COLS + 1, 2047));
            else if (pick < 4)
                cols_val = CFG_DATA_W'($urandom_range(25, 64));
            else
                cols_val = CFG_DATA_W'($urandom_range(MIN_DIM, 24));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                rows_val = CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
            else if (pick == 1)
                rows_val = CFG_DATA_W'($urandom_range(MAX_ROWS + 1, 2047));
            else
                rows_val = CFG_DATA_W'($urandom_range(MIN_DIM, 14));
            pick = $urandom_range(0, 9);
            if (pick < 6)
                style = PIX_UNIFORM;
            else
                style = pixel_style_t'($urandom_range(PIX_WHITE, PIX_TWO_LEVEL));
            count = $urandom_range(80, 300);
            run_phase(cols_val, rows_val, count, style, 1'b0, 1'b1);
            random_sent += count;
        end

        drain();
        if (sb.pending() != 0)
            report_mismatch($sformatf("%0d means never arrived", sb.pending()));
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("tb: done, errors");
        $finish;
    end

endmodule
